### rtl/abcm_pkg.sv
// ----------------------------------------------------------------------------
// abcm_pkg
// Types and constants shared by the audio band color mapper and its checker.
// ----------------------------------------------------------------------------
package abcm_pkg;

  typedef struct packed {
    logic [6:0]  bin_index;
    logic [15:0] bin_value;
    logic        last_bin;
  } in_item_t;

  typedef struct packed {
    logic [7:0] color_index;
    logic [7:0] brightness;
    logic [1:0] dominant_band;
  } out_item_t;

  // Bins at or above this index take no part in the sums
  localparam int BIN_COUNT = 128;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SUB_BASS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BASS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_PRESENCE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BRILLIANCE = 3'd4;

  localparam int GAIN_W   = 10;
  localparam int WEIGHT_W = 12;
  localparam int VAL_W    = 16;
  localparam int MID_W    = 22;
  localparam int PROD_W   = 28;
  localparam int BAND_W   = 34;
  localparam int MPROD_W  = 32;
  localparam int COLOR_W  = 16;
  localparam int NUM_BANDS = 4;

  localparam logic [GAIN_W-1:0]   MID_GAIN_RST = 10'd200;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST [NUM_BANDS] =
      '{12'd1024, 12'd410, 12'd269, 12'd358};

  // Brightness window on mid_sum*mid_gain (Q.16)
  localparam logic [MPROD_W-1:0] BRIGHT_HI  = 32'(305 * 65536);
  localparam logic [MPROD_W-1:0] BRIGHT_LO  = 32'(50 * 65536);
  localparam logic [15:0]        BRIGHT_OFS = 16'd50;

  // Color update
  localparam logic [7:0]         SEED_STEP   = 8'd80;
  localparam logic [COLOR_W-1:0] JUMP_DELTA  = 16'(150 * 256);
  localparam logic [7:0]         HOLD_UP_MIN = 8'd80;
  localparam logic [7:0]         HOLD_DN_MIN = 8'd50;
  localparam logic [7:0]         HOLD_MAX    = 8'd255;

  // floor(y/3) = (y * RECIP3) >> RECIP_SHIFT, exact for y < 2^18
  localparam logic [17:0] RECIP3      = 18'd174763;
  localparam int          RECIP_SHIFT = 19;

endpackage

### rtl/audio_band_color_mapper.sv
// ----------------------------------------------------------------------------
// audio_band_color_mapper
// Folds a stream of FFT bins into band levels and emits one color result
// per spectrum frame.
// ----------------------------------------------------------------------------
// Input channel: one FFT bin per item (index, Q0.16 magnitude, last flag),
// valid/ready. Bins may enter back to back, one per cycle while in_ready_o
// is high. Output channel: one result item per frame, produced by the item
// that carries last_bin. Pipeline: the last bin passes the input register,
// multiply, accumulate, band pick and mid gain, and the color update into
// the output queue, where out_valid_o rises. Throughput: one bin per cycle
// while in_ready_o is high; the accumulators are cleared in the same cycle a
// frame closes, so the next frame may follow at once.
// Results wait in a FIFO_DEPTH deep output queue. in_ready_o drops only when
// FIFO_DEPTH results are outstanding (in flight or queued), so a stalled
// receiver throttles the input only after that many frames. FIFO_DEPTH must
// be 5 or more.
// Configuration: cfg_we_i writes mid_gain (index 0) or a band weight (1..4);
// the user must write only while the block is idle; it is not enforced. Reset
// restores register defaults, clears sums, color, hold counter, output queue.
// ----------------------------------------------------------------------------
module audio_band_color_mapper import abcm_pkg::*; #(
  parameter int FIFO_DEPTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration registers
  logic [GAIN_W-1:0]   mid_gain_q;
  logic [WEIGHT_W-1:0] weight_q [NUM_BANDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_gain_q <= MID_GAIN_RST;
      for (int b = 0; b < NUM_BANDS; b++) begin
        weight_q[b] <= WEIGHT_RST[b];
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MID_GAIN:          mid_gain_q  <= cfg_wdata_i[GAIN_W-1:0];
        REG_WEIGHT_SUB_BASS:   weight_q[0] <= cfg_wdata_i;
        REG_WEIGHT_BASS:       weight_q[1] <= cfg_wdata_i;
        REG_WEIGHT_PRESENCE:   weight_q[2] <= cfg_wdata_i;
        REG_WEIGHT_BRILLIANCE: weight_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshakes and outstanding result count
  logic             in_acc, out_acc;
  logic [CNT_W-1:0] pend_q, pend_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             s3_valid_q;

  assign in_ready_o  = pend_q < CNT_W'(FIFO_DEPTH);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = fill_q != '0;
  assign out_acc     = out_valid_o && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && in_item_i.last_bin) begin
      pend_d = pend_d + 1'b1;
    end
    if (out_acc) begin
      pend_d = pend_d - 1'b1;
    end
    fill_d = fill_q;
    if (s3_valid_q) begin
      fill_d = fill_d + 1'b1;
    end
    if (out_acc) begin
      fill_d = fill_d - 1'b1;
    end
  end

  // Stage 0: input register
  logic     s0_valid_q;
  in_item_t s0_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_item_q <= in_item_i;
    end
  end

  // Stage 1: decode bin and weight it
  logic        in_range, mid_hit, band_hit;
  logic [1:0]  band_sel;
  logic [PROD_W-1:0] prod;

  always_comb begin
    in_range = {3'b000, s0_item_q.bin_index} < 10'(BIN_COUNT);
    mid_hit  = in_range && (s0_item_q.bin_index inside {[7'd15:7'd50]});
    band_hit = in_range;
    band_sel = 2'd0;
    if (s0_item_q.bin_index inside {[7'd9:7'd12]}) begin
      band_sel = 2'd0;
    end else if (s0_item_q.bin_index inside {[7'd13:7'd24]}) begin
      band_sel = 2'd1;
    end else if (s0_item_q.bin_index inside {[7'd25:7'd49]}) begin
      band_sel = 2'd2;
    end else if (s0_item_q.bin_index inside {[7'd50:7'd83]}) begin
      band_sel = 2'd3;
    end else begin
      band_hit = 1'b0;
    end
    prod = PROD_W'(s0_item_q.bin_value) * PROD_W'(weight_q[band_sel]);
  end

  logic              s1_valid_q, s1_last_q, s1_mid_hit_q, s1_band_hit_q;
  logic [1:0]        s1_band_q;
  logic [VAL_W-1:0]  s1_val_q;
  logic [PROD_W-1:0] s1_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q     <= s0_item_q.last_bin;
    s1_mid_hit_q  <= mid_hit;
    s1_band_hit_q <= band_hit;
    s1_band_q     <= band_sel;
    s1_val_q      <= s0_item_q.bin_value;
    s1_prod_q     <= prod;
  end

  // Stage 2: saturating accumulate, snapshot and clear on the last bin
  logic [MID_W-1:0]  mid_sum_q, mid_next;
  logic [MID_W:0]    mid_add;
  logic [BAND_W-1:0] band_sum_q [NUM_BANDS];
  logic [BAND_W-1:0] band_next  [NUM_BANDS];
  logic [BAND_W:0]   band_add   [NUM_BANDS];
  logic              frame_end;

  always_comb begin
    frame_end = s1_valid_q && s1_last_q;
    mid_add   = {1'b0, mid_sum_q} + (MID_W+1)'(s1_val_q);
    mid_next  = mid_sum_q;
    if (s1_valid_q && s1_mid_hit_q) begin
      mid_next = mid_add[MID_W] ? '1 : mid_add[MID_W-1:0];
    end
    for (int b = 0; b < NUM_BANDS; b++) begin
      band_add[b]  = {1'b0, band_sum_q[b]} + (BAND_W+1)'(s1_prod_q);
      band_next[b] = band_sum_q[b];
      if (s1_valid_q && s1_band_hit_q && (s1_band_q == 2'(b))) begin
        band_next[b] = band_add[b][BAND_W] ? '1 : band_add[b][BAND_W-1:0];
      end
    end
  end

  logic              snap_valid_q;
  logic [MID_W-1:0]  snap_mid_q;
  logic [BAND_W-1:0] snap_band_q [NUM_BANDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_sum_q    <= '0;
      snap_valid_q <= 1'b0;
      for (int b = 0; b < NUM_BANDS; b++) begin
        band_sum_q[b] <= '0;
      end
    end else begin
      snap_valid_q <= frame_end;
      if (frame_end) begin
        mid_sum_q <= '0;
        for (int b = 0; b < NUM_BANDS; b++) begin
          band_sum_q[b] <= '0;
        end
      end else begin
        mid_sum_q <= mid_next;
        for (int b = 0; b < NUM_BANDS; b++) begin
          band_sum_q[b] <= band_next[b];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      snap_mid_q <= mid_next;
      for (int b = 0; b < NUM_BANDS; b++) begin
        snap_band_q[b] <= band_next[b];
      end
    end
  end

  // Stage 3: strongest band (earlier band wins ties) and mid gain
  logic [1:0]         win01, win23, best;
  logic [BAND_W-1:0]  val01, val23;
  logic [MPROD_W-1:0] mid_prod;

  always_comb begin
    win01 = (snap_band_q[1] > snap_band_q[0]) ? 2'd1 : 2'd0;
    val01 = (snap_band_q[1] > snap_band_q[0]) ? snap_band_q[1] : snap_band_q[0];
    win23 = (snap_band_q[3] > snap_band_q[2]) ? 2'd3 : 2'd2;
    val23 = (snap_band_q[3] > snap_band_q[2]) ? snap_band_q[3] : snap_band_q[2];
    best  = (val23 > val01) ? win23 : win01;
    mid_prod = MPROD_W'(snap_mid_q) * MPROD_W'(mid_gain_q);
  end

  logic [1:0]         s3_best_q;
  logic [MPROD_W-1:0] s3_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_best_q <= best;
    s3_prod_q <= mid_prod;
  end

  // Stage 4: brightness and color update
  logic [7:0]         bright, seed_int, hold_q, hold_base, hold_next;
  logic [15:0]        bright_diff;
  logic [COLOR_W-1:0] prev_q, seed, smooth, color_next;
  logic [COLOR_W:0]   hi_thr;
  logic [19:0]        mix;
  logic [35:0]        third;
  logic               jump_up, jump_dn, jump;

  always_comb begin
    bright_diff = s3_prod_q[MPROD_W-1:16] - BRIGHT_OFS;
    if (s3_prod_q > BRIGHT_HI) begin
      bright = 8'hFF;
    end else if (s3_prod_q < BRIGHT_LO) begin
      bright = 8'h00;
    end else begin
      bright = bright_diff[7:0];
    end

    seed_int = {6'b000000, s3_best_q} * SEED_STEP;
    seed     = {seed_int, 8'h00};

    hi_thr  = {1'b0, prev_q} + (COLOR_W+1)'(JUMP_DELTA);
    jump_up = ({1'b0, seed} > hi_thr) && (hold_q > HOLD_UP_MIN);
    jump_dn = (prev_q >= JUMP_DELTA) && (seed < (prev_q - JUMP_DELTA))
              && (hold_q > HOLD_DN_MIN);
    jump    = jump_up || jump_dn;

    // prev*11 + seed, then /12 as (x>>2)/3 by reciprocal
    mix    = {1'b0, prev_q, 3'b000} + {3'b000, prev_q, 1'b0} + {4'h0, prev_q}
             + {4'h0, seed};
    third  = 36'(mix[19:2]) * 36'(RECIP3);
    smooth = third[RECIP_SHIFT +: COLOR_W];

    color_next = jump ? seed : smooth;
    hold_base  = jump ? 8'h00 : hold_q;
    hold_next  = (hold_base == HOLD_MAX) ? HOLD_MAX : hold_base + 1'b1;
  end

  // Output queue
  out_item_t        fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      hold_q   <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      pend_q   <= '0;
      fill_q   <= '0;
    end else begin
      pend_q <= pend_d;
      fill_q <= fill_d;
      if (s3_valid_q) begin
        prev_q   <= color_next;
        hold_q   <= hold_next;
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (out_acc) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      fifo_q[wr_ptr_q] <= '{color_index:   color_next[COLOR_W-1:8],
                            brightness:    bright,
                            dominant_band: s3_best_q};
    end
  end

  assign out_item_o = fifo_q[rd_ptr_q];

endmodule

### rtl/abcm_checker.sv
// ----------------------------------------------------------------------------
// abcm_checker
// Port-level checks for the audio band color mapper, bound to the top level.
// ----------------------------------------------------------------------------
module abcm_checker import abcm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // A stalled result must hold
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // A closed frame must show its result once it has passed the pipeline
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_o && in_item_i.last_bin |-> ##5 out_valid_o)
    else $error("frame result missing after last bin");

  // With nothing queued, the input must not be throttled
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !out_valid_o |-> in_ready_o)
    else $error("input throttled with an empty output queue");

  // Only a newly accepted last bin can use up the last free slot
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $fell(in_ready_o) |-> $past(in_valid_i && in_ready_o && in_item_i.last_bin))
    else $error("ready dropped without a new frame result");

endmodule

bind audio_band_color_mapper abcm_checker u_abcm_checker (.*);

### tb/audio_band_color_mapper_tb.sv
// ----------------------------------------------------------------------------
// audio_band_color_mapper_tb
// Streams FFT bin items into the mapper and checks each frame result against
// a cycle-free predictor of band sums, brightness and color smoothing. Runs a
// short table of edge-case bins, then random frames under several register
// settings and handshake idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module audio_band_color_mapper_tb;
  import abcm_pkg::*;

  localparam int NUM_DIR_ROWS   = 22;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_SETTLE     = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;

  // Predictor constants
  localparam int          BAND_LO [NUM_BANDS] = '{9, 13, 25, 50};
  localparam int          BAND_HI [NUM_BANDS] = '{12, 24, 49, 83};
  localparam int          MID_FIRST    = 15;
  localparam int          MID_LAST     = 50;
  localparam int unsigned LEVEL_CEIL   = 305 * 65536;
  localparam int unsigned LEVEL_FLOOR  = 50 * 65536;
  localparam int unsigned LEVEL_OFFSET = 50;
  localparam int unsigned HUE_STEP     = 80 * 256;
  localparam int unsigned HUE_SPAN     = 150 * 256;
  localparam int unsigned HOLD_FOR_UP  = 80;
  localparam int unsigned HOLD_FOR_DN  = 50;
  localparam int unsigned SMOOTH_KEEP  = 11;
  localparam int unsigned SMOOTH_DIV   = 12;

  localparam logic [CFG_IDX_W-1:0] WEIGHT_REG [NUM_BANDS] =
      '{REG_WEIGHT_SUB_BASS, REG_WEIGHT_BASS, REG_WEIGHT_PRESENCE, REG_WEIGHT_BRILLIANCE};

  typedef struct packed {
    in_item_t  bin;
    logic      given;
    out_item_t want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
    // empty frame straight after reset, then a last bin outside every band
    '{'{7'd0,   16'h0000, 1'b1}, 1'b1, '{8'd0, 8'd0, 2'd0}},
    '{'{7'd127, 16'hFFFF, 1'b1}, 1'b1, '{8'd0, 8'd0, 2'd0}},
    // band and mid edges, mostly at full scale
    '{'{7'd8,   16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{7'd9,   16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{7'd12,  16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{7'd13,  16'h0001, 1'b0}, 1'b0, '0},
    '{'{7'd14,  16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{7'd15,  16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{7'd24,  16'h8000, 1'b0}, 1'b0, '0},
    '{'{7'd25,  16'h0000, 1'b0}, 1'b0, '0},
    '{'{7'd49,  16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{7'd50,  16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{7'd51,  16'h1234, 1'b0}, 1'b0, '0},
    '{'{7'd83,  16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{7'd84,  16'hFFFF, 1'b1}, 1'b0, '0},
    // brightness: exactly at the lower threshold, just below, one step above
    '{'{7'd20,  16'd16384, 1'b1}, 1'b0, '0},
    '{'{7'd20,  16'd16383, 1'b1}, 1'b0, '0},
    '{'{7'd30,  16'd16712, 1'b1}, 1'b0, '0},
    // brightness one below the ceiling
    '{'{7'd30,  16'd50000, 1'b0}, 1'b0, '0},
    '{'{7'd31,  16'd49942, 1'b1}, 1'b0, '0},
    // equal weighted sums in bands 0 and 1: the first band wins the tie
    '{'{7'd10,  16'd410,  1'b0}, 1'b0, '0},
    '{'{7'd20,  16'd1024, 1'b1}, 1'b0, '0}
  };

  logic      clk_i;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predictor state and registers
  logic [GAIN_W-1:0]   gain_reg;
  logic [WEIGHT_W-1:0] weight_reg [NUM_BANDS];
  logic [MID_W-1:0]    mid_acc;
  logic [BAND_W-1:0]   band_acc [NUM_BANDS];
  logic [COLOR_W-1:0]  hue_q88;
  logic [7:0]          hold_cnt;

  out_item_t frame_results_q [$];

  int mismatches    = 0;
  int bins_sent     = 0;
  int idle_cycles   = 0;
  int sender_gap_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold_req  = 0;
  int lead_band      = 0;
  int segment_left   = 0;

  audio_band_color_mapper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Accumulate one bin; on a last bin close the frame and return its result.
  function automatic bit fold_bin(input in_item_t bin, output out_item_t res);
    logic [MID_W:0]     mid_next;
    logic [PROD_W-1:0]  weighted;
    logic [BAND_W:0]    band_next;
    logic [MPROD_W-1:0] level;
    logic [COLOR_W-1:0] seed;
    int unsigned        blend;
    int                 band_hit;
    int                 best;
    res = '0;
    band_hit = -1;
    if (int'(bin.bin_index) < BIN_COUNT) begin
      if (int'(bin.bin_index) >= MID_FIRST && int'(bin.bin_index) <= MID_LAST) begin
        mid_next = {1'b0, mid_acc} + (MID_W+1)'(bin.bin_value);
        mid_acc = mid_next[MID_W] ? '1 : mid_next[MID_W-1:0];
      end
      for (int b = 0; b < NUM_BANDS; b++)
        if (int'(bin.bin_index) >= BAND_LO[b] && int'(bin.bin_index) <= BAND_HI[b])
          band_hit = b;
      if (band_hit >= 0) begin
        weighted = PROD_W'(bin.bin_value) * PROD_W'(weight_reg[band_hit]);
        band_next = {1'b0, band_acc[band_hit]} + (BAND_W+1)'(weighted);
        band_acc[band_hit] = band_next[BAND_W] ? '1 : band_next[BAND_W-1:0];
      end
    end
    if (!bin.last_bin) return 1'b0;

    best = 0;
    for (int b = 1; b < NUM_BANDS; b++)
      if (band_acc[b] > band_acc[best]) best = b;

    level = MPROD_W'(mid_acc) * MPROD_W'(gain_reg);
    if (level > LEVEL_CEIL)       res.brightness = 8'd255;
    else if (level < LEVEL_FLOOR) res.brightness = 8'd0;
    else                          res.brightness = 8'(level[31:16] - LEVEL_OFFSET);

    seed = COLOR_W'(best * HUE_STEP);
    if (int'(seed) > int'(hue_q88) + int'(HUE_SPAN) && 32'(hold_cnt) > HOLD_FOR_UP) begin
      hue_q88 = seed;
      hold_cnt = '0;
    end else if (32'(hue_q88) >= HUE_SPAN && 32'(seed) < 32'(hue_q88) - HUE_SPAN &&
                 32'(hold_cnt) > HOLD_FOR_DN) begin
      hue_q88 = seed;
      hold_cnt = '0;
    end else begin
      blend = 32'(hue_q88) * SMOOTH_KEEP + 32'(seed);
      hue_q88 = COLOR_W'(blend / SMOOTH_DIV);
    end
    if (hold_cnt != 8'hFF) hold_cnt++;

    res.color_index   = hue_q88[15:8];
    res.dominant_band = 2'(best);
    mid_acc = '0;
    for (int b = 0; b < NUM_BANDS; b++) band_acc[b] = '0;
    return 1'b1;
  endfunction

  task automatic send_bin(input in_item_t bin, input bit use_given, input out_item_t given);
    out_item_t predicted;
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= bin;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    bins_sent++;
    if (fold_bin(bin, predicted)) frame_results_q.push_back(use_given ? given : predicted);
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic drain_results(input int settle);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [GAIN_W-1:0] gain,
                               input logic [NUM_BANDS-1:0][WEIGHT_W-1:0] wts);
    drain_results(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MID_GAIN;
    cfg_wdata <= CFG_DATA_W'(gain);
    @(posedge clk_i);
    gain_reg = gain;
    for (int b = 0; b < NUM_BANDS; b++) begin
      cfg_index <= WEIGHT_REG[b];
      cfg_wdata <= wts[b];
      @(posedge clk_i);
      weight_reg[b] = wts[b];
    end
    cfg_we <= 1'b0;
  endtask

  // lead < 0: noise or a one-bin pile; else most bins land in the lead band.
  task automatic send_frame(input int lead);
    in_item_t bin;
    int       n_bins;
    bit       pile;
    pile = ($urandom_range(59) == 0);
    n_bins = pile ? $urandom_range(64, 100) : $urandom_range(1, 4);
    bin.bin_index = 7'($urandom_range(0, 127));
    if (pile && lead >= 0) bin.bin_index = 7'($urandom_range(BAND_LO[lead], BAND_HI[lead]));
    for (int k = 0; k < n_bins; k++) begin
      if (pile) begin
        // hammer one bin near full scale to drive the sums into saturation
        bin.bin_value = 16'hFFFF - 16'($urandom_range(0, 255));
      end else if (lead < 0) begin
        bin.bin_index = 7'($urandom_range(0, 127));
        bin.bin_value = 16'($urandom());
      end else if ($urandom_range(9) < 7) begin
        bin.bin_index = 7'($urandom_range(BAND_LO[lead], BAND_HI[lead]));
        bin.bin_value = 16'($urandom_range(16'h4000, 16'hFFFF));
      end else begin
        bin.bin_index = 7'($urandom_range(0, 127));
        bin.bin_value = 16'($urandom_range(0, 16'h0FFF));
      end
      bin.last_bin = (k == n_bins - 1);
      send_bin(bin, 1'b0, '0);
    end
  endtask

  // Long runs on one lead band, swapping to the mirrored band (0 and 3, 1 and
  // 2) most of the time, so the hold counter gets past both jump thresholds.
  task automatic run_random(input int budget);
    int stop_at;
    stop_at = bins_sent + budget;
    while (bins_sent < stop_at) begin
      if (segment_left == 0) begin
        lead_band = ($urandom_range(9) < 7) ? NUM_BANDS - 1 - lead_band
                                            : $urandom_range(0, NUM_BANDS - 1);
        segment_left = $urandom_range(40, 120);
      end
      send_frame(($urandom_range(9) == 0) ? -1 : lead_band);
      segment_left--;
    end
  endtask

  // Result side: ready pattern, with a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (recv_hold_req > 0) begin
        hold_left = recv_hold_req;
        recv_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_results_q.size() == 0) begin
        $display("%0t: unexpected result color %0d brightness %0d band %0d", $time,
                 out_item.color_index, out_item.brightness, out_item.dominant_band);
        mismatches++;
      end else begin
        want = frame_results_q.pop_front();
        if (out_item.color_index !== want.color_index) begin
          $display("%0t: color_index expected %0d actual %0d", $time,
                   want.color_index, out_item.color_index);
          mismatches++;
        end
        if (out_item.brightness !== want.brightness) begin
          $display("%0t: brightness expected %0d actual %0d", $time,
                   want.brightness, out_item.brightness);
          mismatches++;
        end
        if (out_item.dominant_band !== want.dominant_band) begin
          $display("%0t: dominant_band expected %0d actual %0d", $time,
                   want.dominant_band, out_item.dominant_band);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("audio_band_color_mapper regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [NUM_BANDS-1:0][WEIGHT_W-1:0] wts;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_MID_GAIN;
    cfg_wdata = '0;
    rst_n     = 1'b0;

    gain_reg      = 10'd200;
    weight_reg[0] = 12'd1024;
    weight_reg[1] = 12'd410;
    weight_reg[2] = 12'd269;
    weight_reg[3] = 12'd358;
    mid_acc  = '0;
    hue_q88  = '0;
    hold_cnt = '0;
    for (int b = 0; b < NUM_BANDS; b++) band_acc[b] = '0;

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_DIR_ROWS; r++)
      send_bin(DIR_ROWS[r].bin, DIR_ROWS[r].given, DIR_ROWS[r].want);

    // every register at its top, no idling
    load_settings(10'h3FF, {NUM_BANDS{12'hFFF}});
    run_random(380);

    sender_gap_pct = 46;
    for (int b = 0; b < NUM_BANDS; b++) wts[b] = WEIGHT_W'($urandom_range(0, 4095));
    load_settings(GAIN_W'($urandom_range(0, 1023)), wts);
    run_random(380);

    // all registers zero; fill the result queue behind a long hold-off
    sender_gap_pct = 0;
    recv_stall_pct = 46;
    load_settings('0, '0);
    recv_hold_req = LONG_HOLD;
    run_random(120);

    sender_gap_pct = 23;
    recv_stall_pct = 23;
    load_settings(10'd200, {12'd358, 12'd269, 12'd410, 12'd1024});
    run_random(190);
    drain_results(0);
    run_random(190);

    sender_gap_pct = 0;
    recv_stall_pct = 46;
    for (int b = 0; b < NUM_BANDS; b++) wts[b] = WEIGHT_W'($urandom_range(0, 4095));
    load_settings(GAIN_W'($urandom_range(0, 1023)), wts);
    recv_hold_req = LONG_HOLD;
    run_random(380);

    drain_results(END_SETTLE);
    if (mismatches == 0) begin
      $display("audio_band_color_mapper regression: pass");
    end else begin
      $display("audio_band_color_mapper regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/abcm_pkg.sv
rtl/audio_band_color_mapper.sv
rtl/abcm_checker.sv
tb/audio_band_color_mapper_tb.sv
